@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

@@ sv/rhsl_pkg.sv @@
package rhsl_pkg;

    localparam int NumCells = 16;
    localparam int DenW     = 11;
    localparam int QuoW     = 16;
    localparam int Latency  = NumCells + 1;

    localparam int LaneHue = 0;
    localparam int LaneSat = 1;
    localparam int LaneLum = 2;
    localparam int NumLanes = 3;

    localparam logic [DenW-1:0] LumDen = DenW'(510);
    localparam logic [QuoW-1:0] QuoMax = '1;

    typedef struct packed {
        logic [DenW-1:0] rem;
        logic [DenW-1:0] den;
        logic [QuoW-1:0] quo;
        logic            full;
    } lane_t;

    typedef struct packed {
        logic                       grey;
        logic [7:0]                 alpha;
        lane_t [NumLanes-1:0]       lane;
    } stage_t;

endpackage

@@ sv/rhsl_prep.sv @@
module rhsl_prep (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          pixel_argb,
    output logic                 valid,
    output rhsl_pkg::stage_t     stage
);
    import rhsl_pkg::*;

    logic [7:0]          r, g, b, mx, mn;
    logic [8:0]          d, s, sat_den;
    logic [DenW-1:0]     d6;
    logic signed [11:0]  hnum;
    logic [DenW-1:0]     hnum_u;
    stage_t              stage_next, stage_reg;
    logic                valid_reg;

    always_comb
    begin
        r = pixel_argb[23:16];
        g = pixel_argb[15:8];
        b = pixel_argb[7:0];
        mx = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        d  = {1'b0, mx} - {1'b0, mn};
        s  = {1'b0, mx} + {1'b0, mn};
        d6 = {d, 2'b00} + {1'b0, d, 1'b0};
        sat_den = (s < 9'd255) ? s : (9'd510 - s);
        if (mx == r)
        begin
            hnum = $signed({4'b0, g}) - $signed({4'b0, b});
        end
        else if (mx == g)
        begin
            hnum = $signed({2'b0, d, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
        end
        else
        begin
            hnum = $signed({1'b0, d, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
        end
        if (hnum < 0)
        begin
            hnum = hnum + $signed({1'b0, d6});
        end
        hnum_u = hnum[DenW-1:0];

        stage_next.grey  = (d == 9'd0);
        stage_next.alpha = pixel_argb[31:24];

        stage_next.lane[LaneHue].rem  = hnum_u;
        stage_next.lane[LaneHue].den  = d6;
        stage_next.lane[LaneHue].quo  = '0;
        stage_next.lane[LaneHue].full = (hnum_u >= d6);

        stage_next.lane[LaneSat].rem  = {2'b0, d};
        stage_next.lane[LaneSat].den  = {2'b0, sat_den};
        stage_next.lane[LaneSat].quo  = '0;
        stage_next.lane[LaneSat].full = (d >= sat_den);

        stage_next.lane[LaneLum].rem  = {2'b0, s};
        stage_next.lane[LaneLum].den  = LumDen;
        stage_next.lane[LaneLum].quo  = '0;
        stage_next.lane[LaneLum].full = ({2'b0, s} >= LumDen);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

@@ sv/rhsl_div_cell.sv @@
module rhsl_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rhsl_pkg::stage_t     in_stage,
    output logic                 out_valid,
    output rhsl_pkg::stage_t     out_stage
);
    import rhsl_pkg::*;

    stage_t          stage_next, stage_reg;
    logic            valid_reg;
    logic [DenW:0]   twice;
    logic [DenW:0]   diff;

    // One restoring quotient bit per lane.
    always_comb
    begin
        stage_next = in_stage;
        twice = '0;
        diff  = '0;
        for (int i = 0; i < NumLanes; i++)
        begin
            twice = {in_stage.lane[i].rem, 1'b0};
            diff  = twice - {1'b0, in_stage.lane[i].den};
            if (twice >= {1'b0, in_stage.lane[i].den})
            begin
                stage_next.lane[i].rem = diff[DenW-1:0];
                stage_next.lane[i].quo = {in_stage.lane[i].quo[QuoW-2:0], 1'b1};
            end
            else
            begin
                stage_next.lane[i].rem = twice[DenW-1:0];
                stage_next.lane[i].quo = {in_stage.lane[i].quo[QuoW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

@@ sv/rgb_to_hsl_converter.sv @@
// RGB to HSL pixel converter.
// A transfer on the input side happens at a rising edge with start high and
// busy low; pixel_argb carries alpha, red, green and blue in that byte order.
// Busy is always low, so one pixel can be taken in every clock cycle.
// Each pixel gives one result on hue, saturation, lightness and alpha, shown
// for exactly one cycle with strobe high. A prep register finds maximum,
// minimum and the three dividends and divisors; then a row of 16 identical
// cells each adds one quotient bit to all three divisions, so the prep register
// and the row of cells set the latency and the rate is one pixel per cycle.
// Results leave in the order the pixels came in.
// Reset clears every valid flag at once, so no strobe follows reset until a
// new pixel has been taken in.
// The receiver cannot hold results off; every result is taken in the cycle
// it is shown.
module rgb_to_hsl_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] pixel_argb,
    output logic        strobe,
    output logic [15:0] hue,
    output logic [15:0] saturation,
    output logic [15:0] lightness,
    output logic [7:0]  alpha
);
    import rhsl_pkg::*;

    logic   chain_valid [0:NumCells];
    stage_t chain_stage [0:NumCells];
    stage_t last;

    assign busy = 1'b0;

    rhsl_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .pixel_argb (pixel_argb),
        .valid      (chain_valid[0]),
        .stage      (chain_stage[0])
    );

    for (genvar k = 0; k < NumCells; k++)
    begin : g_cell
        rhsl_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_stage  (chain_stage[k]),
            .out_valid (chain_valid[k+1]),
            .out_stage (chain_stage[k+1])
        );
    end

    assign last   = chain_stage[NumCells];
    assign strobe = chain_valid[NumCells];
    assign alpha  = last.alpha;

    always_comb
    begin
        if (last.grey)
        begin
            hue        = '0;
            saturation = '0;
        end
        else
        begin
            hue        = last.lane[LaneHue].full ? QuoMax : last.lane[LaneHue].quo;
            saturation = last.lane[LaneSat].full ? QuoMax : last.lane[LaneSat].quo;
        end
        lightness = last.lane[LaneLum].full ? QuoMax : last.lane[LaneLum].quo;
    end

endmodule

@@ sv/rhsl_checker.sv @@
`include "assert_macros.svh"

module rhsl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] pixel_argb,
    input logic        strobe,
    input logic [15:0] hue,
    input logic [15:0] saturation,
    input logic [7:0]  alpha
);
    import rhsl_pkg::*;

    logic pixel_grey;

    assign pixel_grey = (pixel_argb[23:16] == pixel_argb[15:8])
                     && (pixel_argb[15:8] == pixel_argb[7:0]);

    `ASSERT_CLK(a_result_follows, clk, rst_n, (start && !busy) |-> ##Latency strobe,
                "missing result")
    `ASSERT_CLK(a_alpha_kept, clk, rst_n,
                strobe |-> (alpha == $past(pixel_argb[31:24], Latency)), "alpha changed")
    `ASSERT_CLK(a_grey_zero, clk, rst_n, (strobe && $past(pixel_grey, Latency))
                |-> (hue == 16'd0 && saturation == 16'd0), "grey pixel not zero")
    `ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy raised")

endmodule

bind rgb_to_hsl_converter rhsl_checker u_rhsl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .pixel_argb (pixel_argb),
    .strobe     (strobe),
    .hue        (hue),
    .saturation (saturation),
    .alpha      (alpha)
);

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] pixel_argb;
    logic        strobe;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
    logic [7:0]  alpha;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] lum;
        logic [7:0]  alpha;
    } hsl_t;

    hsl_t pending_hsl[$];
    int   errors;
    int   results_seen;
    int   pixels_sent;
    int   idle_pct;

    rgb_to_hsl_converter dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel_argb(pixel_argb),
        .strobe(strobe),
        .hue(hue),
        .saturation(saturation),
        .lightness(lightness),
        .alpha(alpha)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] frac_q16(input int unsigned num, input int unsigned den);
        longint unsigned q;
        if (den == 0)
        begin
            return 16'd0;
        end
        q = (longint'(num) * 65536) / den;
        if (q > 65535)
        begin
            q = 65535;
        end
        return q[15:0];
    endfunction

    function automatic hsl_t convert_pixel(input logic [31:0] px);
        hsl_t res;
        int r, g, b, mx, mn, d, s, num;
        r = px[23:16];
        g = px[15:8];
        b = px[7:0];
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        s = mx + mn;
        res.alpha = px[31:24];
        res.lum = frac_q16(s, 510);
        res.hue = 16'd0;
        res.sat = 16'd0;
        if (d != 0)
        begin
            res.sat = (s < 255) ? frac_q16(d, s) : frac_q16(d, 510 - s);
            if (mx == r)
            begin
                num = g - b;
            end
            else if (mx == g)
            begin
                num = 2 * d + (b - r);
            end
            else
            begin
                num = 4 * d + (r - g);
            end
            if (num < 0)
            begin
                num += 6 * d;
            end
            res.hue = frac_q16(num, 6 * d);
        end
        return res;
    endfunction

    task automatic send_pixel(input logic [31:0] px);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel_argb <= px;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_hsl.push_back(convert_pixel(px));
        pixels_sent++;
    endtask

    always @(posedge clk)
    begin
        hsl_t want;
        if (rst_n && strobe)
        begin
            results_seen++;
            if (pending_hsl.size() == 0)
            begin
                $display("%0t: result with no pixel pending, got %h %h %h %h", $time,
                         hue, saturation, lightness, alpha);
                errors++;
            end
            else
            begin
                want = pending_hsl.pop_front();
                if (hue !== want.hue)
                begin
                    $display("%0t: hue expected %h actual %h", $time, want.hue, hue);
                    errors++;
                end
                if (saturation !== want.sat)
                begin
                    $display("%0t: saturation expected %h actual %h", $time,
                             want.sat, saturation);
                    errors++;
                end
                if (lightness !== want.lum)
                begin
                    $display("%0t: lightness expected %h actual %h", $time,
                             want.lum, lightness);
                    errors++;
                end
                if (alpha !== want.alpha)
                begin
                    $display("%0t: alpha expected %h actual %h", $time, want.alpha, alpha);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_pixel(32'h00000000);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'h80808080);
        send_pixel(32'hFFFF0000);
        send_pixel(32'h0000FF00);
        send_pixel(32'h120000FF);
        send_pixel(32'h00FFFF00);
        send_pixel(32'h0000FFFF);
        send_pixel(32'h00FF00FF);
        send_pixel(32'h00FF0001);
        send_pixel(32'h00FF7F80);
        send_pixel(32'h00010000);
        send_pixel(32'h00FEFFFF);
        send_pixel(32'hAA7F8080);
        send_pixel(32'h55808080);
        send_pixel(32'h00807F7F);
        send_pixel(32'h00FFFFFE);
        send_pixel(32'h01FF00FE);
    endtask

    task automatic test_random(input int count);
        logic [31:0] px;
        for (int i = 0; i < count; i++)
        begin
            px = $urandom;
            if ($urandom_range(9) == 0)
            begin
                px[15:8] = px[23:16];
                px[7:0] = px[23:16];
            end
            else if ($urandom_range(9) == 0)
            begin
                px[15:8] = px[23:16];
            end
            send_pixel(px);
        end
    endtask

    initial
    begin
        errors = 0;
        results_seen = 0;
        pixels_sent = 0;
        idle_pct = 13;
        rst_n = 1'b0;
        start = 1'b0;
        pixel_argb = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(330);
        idle_pct = 59;
        test_random(330);
        idle_pct = 0;
        test_random(340);
        start <= 1'b0;
        while (pending_hsl.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        $display("Converted %0d pixels (extremes, greys, ties, random) and checked %0d results.",
                 pixels_sent, results_seen);
        if (errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb: errors");
        $finish;
    end
endmodule
